[sv/assert_macros.svh]
// assertion macros used by the checker file prs_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is low
`define PRS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same, for an implication whose consequent is checked in the cycle after the antecedent
`define PRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/prs_pkg.sv]
// types, codes and compare function for the partial rank sorter
// no dependencies
`default_nettype none

package prs_pkg;

    localparam int KEY_W  = 64;
    localparam int TAG_W  = 16;
    localparam int RANK_W = 6;
    localparam int CFG_W  = 6;

    typedef logic [1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_KEY_SEL    = 2'd0;
    localparam t_cfg_idx CFG_RANK_FIRST = 2'd1;
    localparam t_cfg_idx CFG_RANK_LAST  = 2'd2;

    typedef enum logic [1:0] {
        KEY_IN    = 2'd0,
        KEY_OUT   = 2'd1,
        KEY_TOTAL = 2'd2,
        KEY_SEEN  = 2'd3
    } t_key_sel;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic sort;
        logic odd;
        logic shift;
        logic sgn;
    } t_cell_ctl;

    // true if key a ranks strictly above key b
    function automatic logic above(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b,
                                   input logic sgn);
        logic res;
        if (sgn) begin
            res = $signed(a) > $signed(b);
        end else begin
            res = a > b;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[sv/prs_rec_if.sv]
// record input channel: valid/ready and the record fields
// no dependencies
`default_nettype none

interface prs_rec_if;
    logic               valid;
    logic               ready;
    logic [63:0]        in_count;
    logic [63:0]        out_count;
    logic [63:0]        total_count;
    logic signed [63:0] last_seen;
    logic [15:0]        tag;
    logic               last;

    modport source (output valid, in_count, out_count, total_count, last_seen, tag, last,
                    input ready);
    modport sink   (input valid, in_count, out_count, total_count, last_seen, tag, last,
                    output ready);
endinterface

`default_nettype wire

[sv/prs_res_if.sv]
// result output channel: valid/ready and the ranked result fields
// no dependencies
`default_nettype none

interface prs_res_if;
    logic        valid;
    logic        ready;
    logic [5:0]  rank;
    logic [15:0] out_tag;
    logic [63:0] key_value;
    logic        final_res;

    modport source (output valid, rank, out_tag, key_value, final_res, input ready);
    modport sink   (input valid, rank, out_tag, key_value, final_res, output ready);
endinterface

`default_nettype wire

[sv/prs_cell.sv]
// one cell of the sorting chain: holds one key and tag, loads, swaps or shifts
// depends on prs_pkg
`default_nettype none

module prs_cell #(
    parameter int IDX      = 0,
    parameter int DEPTH    = 64,
    parameter int TAG_BITS = 16
) (
    input  wire                              i_clk,
    input  prs_pkg::t_cell_ctl               i_ctl,
    input  wire  [$clog2(DEPTH+1)-1:0]       i_fill,
    input  wire  [$clog2(DEPTH+1)-1:0]       i_n,
    input  wire  [prs_pkg::KEY_W-1:0]        i_load_key,
    input  wire  [TAG_BITS-1:0]              i_load_tag,
    input  wire  [prs_pkg::KEY_W-1:0]        i_left_key,
    input  wire  [TAG_BITS-1:0]              i_left_tag,
    input  wire  [prs_pkg::KEY_W-1:0]        i_right_key,
    input  wire  [TAG_BITS-1:0]              i_right_tag,
    input  wire                              i_swap_right,
    output logic [prs_pkg::KEY_W-1:0]        o_key,
    output logic [TAG_BITS-1:0]              o_tag,
    output logic                             o_swap_left
);
    import prs_pkg::*;

    localparam int CNT_W = $clog2(DEPTH+1);
    localparam logic PAR = 1'((IDX + 1) % 2);
    localparam logic HAS_LEFT = (IDX != 0);

    logic [KEY_W-1:0]    r_key, n_key;
    logic [TAG_BITS-1:0] r_tag, n_tag;
    logic                w_load_me;

    assign w_load_me   = i_ctl.load && (i_fill == CNT_W'(IDX));
    assign o_swap_left = HAS_LEFT && i_ctl.sort && (i_ctl.odd == PAR) &&
                         (CNT_W'(IDX) < i_n) && above(r_key, i_left_key, i_ctl.sgn);

    always_comb begin
        n_key = r_key;
        n_tag = r_tag;
        if (w_load_me) begin
            n_key = i_load_key;
            n_tag = i_load_tag;
        end else if (o_swap_left) begin
            n_key = i_left_key;
            n_tag = i_left_tag;
        end else if (i_swap_right || i_ctl.shift) begin
            n_key = i_right_key;
            n_tag = i_right_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_tag <= n_tag;
    end

    assign o_key = r_key;
    assign o_tag = r_tag;

endmodule

`default_nettype wire

[sv/partial_rank_sorter.sv]
// partial rank sorter: loads one record per cycle, then n odd-even transposition
// passes over the cell chain, then results from the chain head.
// throughput: one record per cycle while loading; one result per cycle while emitting,
// when the output register is empty or being read.
// no record is taken while a set is sorted or emitted.
// synchronous active-low reset clears control and config; cell contents are not reset.
`default_nettype none

module partial_rank_sorter #(
    parameter int DEPTH    = 64,
    parameter int TAG_BITS = 16
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_cfg_we,
    input  prs_pkg::t_cfg_idx         i_cfg_idx,
    input  wire  [prs_pkg::CFG_W-1:0] i_cfg_data,
    prs_rec_if.sink                   i_rec,
    prs_res_if.source                 o_res
);
    import prs_pkg::*;

    localparam int CNT_W = $clog2(DEPTH+1);
    localparam int CW    = ((CNT_W > RANK_W) ? CNT_W : RANK_W) + 1;

    t_key_sel            r_key_sel;
    logic [RANK_W-1:0]   r_rank_first, r_rank_last;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_fill, n_fill;
    logic [CNT_W-1:0]    r_n, n_n;
    logic [CNT_W-1:0]    r_pass, n_pass;
    logic [RANK_W-1:0]   r_rank, n_rank;
    logic [RANK_W-1:0]   r_lo, n_lo;
    logic [RANK_W-1:0]   r_hi, n_hi;
    logic                r_sgn, n_sgn;

    logic                r_o_valid, n_o_valid;
    logic [RANK_W-1:0]   r_o_rank;
    logic [TAG_W-1:0]    r_o_tag;
    logic [KEY_W-1:0]    r_o_key;
    logic                r_o_final;
    logic                w_o_load;

    t_cell_ctl           w_ctl;
    logic                w_acc, w_full, w_free, w_empty;
    logic [CNT_W-1:0]    w_n_new;
    logic [RANK_W-1:0]   w_hi_c;
    logic [KEY_W-1:0]    w_sel_key;

    logic [KEY_W-1:0]    w_key  [DEPTH];
    logic [TAG_BITS-1:0] w_tag  [DEPTH];
    logic                w_swap [DEPTH];

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_sel    <= KEY_TOTAL;
            r_rank_first <= '0;
            r_rank_last  <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KEY_SEL:    r_key_sel    <= t_key_sel'(i_cfg_data[1:0]);
                CFG_RANK_FIRST: r_rank_first <= i_cfg_data;
                CFG_RANK_LAST:  r_rank_last  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (r_key_sel)
            KEY_IN:    w_sel_key = i_rec.in_count;
            KEY_OUT:   w_sel_key = i_rec.out_count;
            KEY_TOTAL: w_sel_key = i_rec.total_count;
            KEY_SEEN:  w_sel_key = i_rec.last_seen;
            default:   w_sel_key = i_rec.total_count;
        endcase
    end

    assign i_rec.ready = (r_state == ST_LOAD);
    assign w_acc       = i_rec.valid && i_rec.ready;
    assign w_full      = (r_fill == CNT_W'(DEPTH));
    assign w_free      = !r_o_valid || o_res.ready;
    assign w_n_new     = w_full ? r_fill : r_fill + CNT_W'(1);
    assign w_empty     = (r_rank_first > r_rank_last) ||
                         (CW'(r_rank_first) >= CW'(w_n_new));
    assign w_hi_c      = (CW'(r_rank_last) > CW'(w_n_new - CNT_W'(1))) ?
                         RANK_W'(w_n_new - CNT_W'(1)) : r_rank_last;

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_n       = r_n;
        n_pass    = r_pass;
        n_rank    = r_rank;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_sgn     = r_sgn;
        w_o_load  = 1'b0;
        w_ctl     = '0;
        w_ctl.sgn = r_sgn;
        w_ctl.odd = r_pass[0];
        case (r_state)
            ST_LOAD: begin
                w_ctl.load = w_acc && !w_full;
                if (w_acc) begin
                    n_fill = w_n_new;
                    if (i_rec.last) begin
                        n_fill = '0;
                        if (!w_empty) begin
                            n_state = ST_SORT;
                            n_n     = w_n_new;
                            n_pass  = '0;
                            n_lo    = r_rank_first;
                            n_hi    = w_hi_c;
                            n_sgn   = (r_key_sel == KEY_SEEN);
                        end
                    end
                end
            end
            ST_SORT: begin
                w_ctl.sort = 1'b1;
                n_pass     = r_pass + CNT_W'(1);
                if (r_pass == r_n - CNT_W'(1)) begin
                    n_state = ST_EMIT;
                    n_rank  = '0;
                end
            end
            ST_EMIT: begin
                if (r_rank < r_lo || w_free) begin
                    w_ctl.shift = 1'b1;
                    n_rank      = r_rank + RANK_W'(1);
                    w_o_load    = (r_rank >= r_lo);
                    if (r_rank == r_hi) begin
                        n_state = ST_LOAD;
                    end
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_fill  <= '0;
            r_n     <= '0;
            r_pass  <= '0;
            r_rank  <= '0;
            r_lo    <= '0;
            r_hi    <= '0;
            r_sgn   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_n     <= n_n;
            r_pass  <= n_pass;
            r_rank  <= n_rank;
            r_lo    <= n_lo;
            r_hi    <= n_hi;
            r_sgn   <= n_sgn;
        end
    end

    // cell chain
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic [KEY_W-1:0]    w_lk, w_rk;
        logic [TAG_BITS-1:0] w_lt, w_rt;
        logic                w_rs;
        if (gi == 0) begin : g_first
            assign w_lk = '0;
            assign w_lt = '0;
        end else begin : g_mid
            assign w_lk = w_key[gi-1];
            assign w_lt = w_tag[gi-1];
        end
        if (gi == DEPTH - 1) begin : g_end
            assign w_rk = '0;
            assign w_rt = '0;
            assign w_rs = 1'b0;
        end else begin : g_body
            assign w_rk = w_key[gi+1];
            assign w_rt = w_tag[gi+1];
            assign w_rs = w_swap[gi+1];
        end
        prs_cell #(
            .IDX      (gi),
            .DEPTH    (DEPTH),
            .TAG_BITS (TAG_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_fill       (r_fill),
            .i_n          (r_n),
            .i_load_key   (w_sel_key),
            .i_load_tag   (TAG_BITS'(i_rec.tag)),
            .i_left_key   (w_lk),
            .i_left_tag   (w_lt),
            .i_right_key  (w_rk),
            .i_right_tag  (w_rt),
            .i_swap_right (w_rs),
            .o_key        (w_key[gi]),
            .o_tag        (w_tag[gi]),
            .o_swap_left  (w_swap[gi])
        );
    end

    // output register
    always_comb begin
        n_o_valid = r_o_valid;
        if (w_o_load) begin
            n_o_valid = 1'b1;
        end else if (o_res.ready) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_o_load) begin
            r_o_rank  <= r_rank;
            r_o_tag   <= TAG_W'(w_tag[0]);
            r_o_key   <= w_key[0];
            r_o_final <= (r_rank == r_hi);
        end
    end

    assign o_res.valid     = r_o_valid;
    assign o_res.rank      = r_o_rank;
    assign o_res.out_tag   = r_o_tag;
    assign o_res.key_value = r_o_key;
    assign o_res.final_res = r_o_final;

endmodule

`default_nettype wire

[sv/prs_checker.sv]
// port-level checks for the partial rank sorter, bound to the top level
// depends on assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module prs_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_ready,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input wire [5:0] i_out_rank,
    input wire       i_out_final
);

    `PRS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result beat dropped while stalled")
    `PRS_ASSERT_NEXT(a_rank_step, i_clk, i_rst_n, i_out_valid && i_out_ready && !i_out_final, !i_out_valid || i_out_rank == $past(i_out_rank) + 6'd1, "result ranks not consecutive")
    `PRS_ASSERT(a_no_load_mid_set, i_clk, i_rst_n, i_out_valid && !i_out_final |-> !i_in_ready, "record taken while a set is emitted")

endmodule

bind partial_rank_sorter prs_checker u_prs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_rec.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_rank  (o_res.rank),
    .i_out_final (o_res.final_res)
);

`default_nettype wire
